// ===== design/bmpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpt_pkg: shared constants and types
// Widths, register indexes, operation and status codes, and the request
// bundle for the modular multiplier.
// ----------------------------------------------------------------------------
package bmpt_pkg;

  localparam int DATA_W      = 31;
  localparam int IDX_W       = 12;
  localparam int TABLE_DEPTH = 4096;
  localparam int CNT_W       = 5;

  localparam logic [DATA_W-1:0] MOD_RESET   = 31'd1000000007;
  localparam logic [IDX_W-1:0]  LIMIT_RESET = 12'd4095;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_LIMIT   = 1'b1;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic              go;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] m;
  } mm_req_t;

endpackage

// ===== design/bmpt_mulmod.sv =====
// ----------------------------------------------------------------------------
// bmpt_mulmod: bit-serial modular multiplier
// Reduces b modulo m one bit per cycle, then forms a*b mod m by Horner
// over the bits of a, doubling and adding in alternate cycles.
// ----------------------------------------------------------------------------
module bmpt_mulmod
  import bmpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mm_req_t           req,
  output logic              done,
  output logic [DATA_W-1:0] result
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RED  = 2'd1;
  localparam logic [1:0] M_DBL  = 2'd2;
  localparam logic [1:0] M_ADD  = 2'd3;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DATA_W - 1);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, m_r, m_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt, acc_r, acc_nxt;
  logic [DATA_W:0]   t, t_red;

  // one shared conditional subtract
  always_comb begin
    case (state_r)
      M_RED:   t = {rem_r, b_r[DATA_W-1]};
      M_DBL:   t = {acc_r, 1'b0};
      M_ADD:   t = a_r[DATA_W-1] ? ({1'b0, acc_r} + {1'b0, rem_r}) : {1'b0, acc_r};
      default: t = '0;
    endcase
    t_red = (t >= {1'b0, m_r}) ? (t - {1'b0, m_r}) : t;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    done_nxt  = 1'b0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    case (state_r)
      M_IDLE: begin
        if (req.go) begin
          a_nxt     = req.a;
          b_nxt     = req.b;
          m_nxt     = req.m;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = M_RED;
        end
      end
      M_RED: begin
        rem_nxt = t_red[DATA_W-1:0];
        b_nxt   = {b_r[DATA_W-2:0], 1'b0};
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = M_DBL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      M_DBL: begin
        acc_nxt   = t_red[DATA_W-1:0];
        state_nxt = M_ADD;
      end
      M_ADD: begin
        acc_nxt = t_red[DATA_W-1:0];
        a_nxt   = {a_r[DATA_W-2:0], 1'b0};
        if (cnt_r == LAST) begin
          done_nxt  = 1'b1;
          state_nxt = M_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = M_DBL;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    m_r   <= m_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

// ===== design/binomial_mod_prime_table_core.sv =====
// ----------------------------------------------------------------------------
// binomial_mod_prime_table_core: factorial tables and nPr / nCr mod a prime
// Builds factorial and inverse factorial tables and answers queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_op, in_n, in_r with start high; the request is
//   taken at an edge where busy is low. Output channel: one result per
//   request, shown for exactly one cycle with out_valid high; the receiver
//   cannot stall, so results are never held.
//   Configuration: cfg_we writes cfg_wdata to modulus (index 0) or
//   table_limit (index 1); write only while busy is low.
//   Sequencing: every modular multiply runs on one bit-serial unit. A query
//   reads the tables, then runs two multiplies in turn; a query answered
//   with an error status returns on the next cycle. A build over limit L
//   runs 2 * L + 31 + popcount(m - 2) multiplies, the square-and-multiply
//   inversion dominating for small L.
//   Tables live in two 4096 x 31 memories with registered reads.
//   Reset: control and configuration registers return to their reset values,
//   the tables are marked not built; the memories themselves are not cleared.
// ----------------------------------------------------------------------------
module binomial_mod_prime_table_core
  import bmpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_n,
  input  logic [IDX_W-1:0]  in_r,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [DATA_W-1:0] out_factorial,
  output logic [DATA_W-1:0] out_inverse_factorial,
  output logic [DATA_W-1:0] out_permutations,
  output logic [DATA_W-1:0] out_combinations,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FACT  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_ML    = 4'd3;
  localparam logic [3:0] S_INV   = 4'd4;
  localparam logic [3:0] S_QRD0  = 4'd5;
  localparam logic [3:0] S_QRD1  = 4'd6;
  localparam logic [3:0] S_QMUL1 = 4'd7;
  localparam logic [3:0] S_QMUL2 = 4'd8;
  localparam logic [CNT_W-1:0] EXP_BITS = CNT_W'(DATA_W);

  logic [DATA_W-1:0] modulus_r;
  logic [IDX_W-1:0]  limit_r;
  logic              built_r, built_nxt;
  logic [IDX_W-1:0]  blim_r, blim_nxt;

  logic [3:0]        state_r, state_nxt;
  logic [DATA_W-1:0] m_r, m_nxt, one_r, one_nxt, cur_r, cur_nxt;
  logic [DATA_W-1:0] base_r, base_nxt, exp_r, exp_nxt, fn_r, fn_nxt, ifn_r, ifn_nxt;
  logic [IDX_W-1:0]  lim_r, lim_nxt, i_r, i_nxt, n_r, n_nxt, r_r, r_nxt;
  logic [CNT_W-1:0]  ecnt_r, ecnt_nxt;
  mm_req_t           req_r, req_nxt;
  logic              mm_done;
  logic [DATA_W-1:0] mm_res;

  logic              ov_r, ov_nxt;
  logic [1:0]        ost_r, ost_nxt;
  logic [DATA_W-1:0] of_r, of_nxt, oi_r, oi_nxt, op_r, op_nxt, oc_r, oc_nxt;

  logic [DATA_W-1:0] fact_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] inv_mem  [TABLE_DEPTH];
  logic              fact_we, inv_we;
  logic [IDX_W-1:0]  fact_wa, inv_wa, fact_ra, inv_ra;
  logic [DATA_W-1:0] fact_wd, inv_wd, fact_q_r, inv_q_r;
  logic [DATA_W-1:0] eff_m;

  assign eff_m = (modulus_r < DATA_W'(2)) ? DATA_W'(1) : modulus_r;

  bmpt_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req_r),
    .done   (mm_done),
    .result (mm_res)
  );

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    blim_nxt  = blim_r;
    m_nxt     = m_r;
    one_nxt   = one_r;
    cur_nxt   = cur_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    fn_nxt    = fn_r;
    ifn_nxt   = ifn_r;
    lim_nxt   = lim_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    ecnt_nxt  = ecnt_r;
    req_nxt   = req_r;
    req_nxt.go = 1'b0;
    ov_nxt    = 1'b0;
    ost_nxt   = ost_r;
    of_nxt    = of_r;
    oi_nxt    = oi_r;
    op_nxt    = op_r;
    oc_nxt    = oc_r;
    fact_we   = 1'b0;
    fact_wa   = i_r;
    fact_wd   = mm_res;
    inv_we    = 1'b0;
    inv_wa    = i_r - 1'b1;
    inv_wd    = mm_res;
    fact_ra   = n_r;
    inv_ra    = n_r;

    case (state_r)
      S_IDLE: begin
        fact_ra = in_n;
        inv_ra  = in_n;
        if (start) begin
          n_nxt  = in_n;
          r_nxt  = in_r;
          m_nxt  = eff_m;
          req_nxt.m = eff_m;
          of_nxt = '0;
          oi_nxt = '0;
          op_nxt = '0;
          oc_nxt = '0;
          if (in_op == OP_BUILD) begin
            lim_nxt = limit_r;
            one_nxt = (eff_m == DATA_W'(1)) ? '0 : DATA_W'(1);
            fact_we = 1'b1;
            fact_wa = '0;
            fact_wd = one_nxt;
            cur_nxt = one_nxt;
            if (limit_r == '0) begin
              // top factorial is 0!: go straight to the inversion
              base_nxt  = one_nxt;
              cur_nxt   = one_nxt;
              exp_nxt   = (eff_m == DATA_W'(1)) ? '0 : eff_m - DATA_W'(2);
              ecnt_nxt  = EXP_BITS;
              req_nxt.go = 1'b1;
              req_nxt.a = one_nxt;
              req_nxt.b = one_nxt;
              state_nxt = S_SQ;
            end else begin
              i_nxt     = IDX_W'(1);
              req_nxt.go = 1'b1;
              req_nxt.a = one_nxt;
              req_nxt.b = DATA_W'(1);
              state_nxt = S_FACT;
            end
          end else if (!built_r) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_NOT_BUILT;
          end else if (in_n > blim_r || in_r > in_n) begin
            ov_nxt  = 1'b1;
            ost_nxt = ST_RANGE;
          end else begin
            state_nxt = S_QRD0;
          end
        end
      end
      S_FACT: begin
        if (mm_done) begin
          fact_we = 1'b1;
          cur_nxt = mm_res;
          if (i_r == lim_r) begin
            base_nxt   = mm_res;
            cur_nxt    = one_r;
            exp_nxt    = (m_r == DATA_W'(1)) ? '0 : m_r - DATA_W'(2);
            ecnt_nxt   = EXP_BITS;
            req_nxt.go = 1'b1;
            req_nxt.a  = one_r;
            req_nxt.b  = one_r;
            state_nxt  = S_SQ;
          end else begin
            i_nxt      = i_r + 1'b1;
            req_nxt.go = 1'b1;
            req_nxt.a  = mm_res;
            req_nxt.b  = DATA_W'(i_r + 1'b1);
          end
        end
      end
      S_SQ, S_ML: begin
        if (mm_done) begin
          cur_nxt = mm_res;
          if (state_r == S_SQ && exp_r[DATA_W-1]) begin
            req_nxt.go = 1'b1;
            req_nxt.a  = mm_res;
            req_nxt.b  = base_r;
            state_nxt  = S_ML;
          end else if (ecnt_r == CNT_W'(1)) begin
            // exponent exhausted: seed the inverse table at the top
            inv_we = 1'b1;
            inv_wa = lim_r;
            i_nxt  = lim_r;
            if (lim_r == '0) begin
              built_nxt = 1'b1;
              blim_nxt  = lim_r;
              ov_nxt    = 1'b1;
              ost_nxt   = ST_OK;
              state_nxt = S_IDLE;
            end else begin
              req_nxt.go = 1'b1;
              req_nxt.a  = mm_res;
              req_nxt.b  = DATA_W'(lim_r);
              state_nxt  = S_INV;
            end
          end else begin
            exp_nxt    = {exp_r[DATA_W-2:0], 1'b0};
            ecnt_nxt   = ecnt_r - 1'b1;
            req_nxt.go = 1'b1;
            req_nxt.a  = mm_res;
            req_nxt.b  = mm_res;
            state_nxt  = S_SQ;
          end
        end
      end
      S_INV: begin
        if (mm_done) begin
          inv_we = 1'b1;
          if (i_r == IDX_W'(1)) begin
            built_nxt = 1'b1;
            blim_nxt  = lim_r;
            ov_nxt    = 1'b1;
            ost_nxt   = ST_OK;
            state_nxt = S_IDLE;
          end else begin
            i_nxt      = i_r - 1'b1;
            req_nxt.go = 1'b1;
            req_nxt.a  = mm_res;
            req_nxt.b  = DATA_W'(i_r - 1'b1);
          end
        end
      end
      S_QRD0: begin
        fn_nxt    = fact_q_r;
        ifn_nxt   = inv_q_r;
        inv_ra    = n_r - r_r;
        state_nxt = S_QRD1;
      end
      S_QRD1: begin
        inv_ra     = r_r;
        req_nxt.go = 1'b1;
        req_nxt.a  = fn_r;
        req_nxt.b  = inv_q_r;
        state_nxt  = S_QMUL1;
      end
      S_QMUL1: begin
        inv_ra = r_r;
        if (mm_done) begin
          op_nxt     = mm_res;
          req_nxt.go = 1'b1;
          req_nxt.a  = mm_res;
          req_nxt.b  = inv_q_r;
          state_nxt  = S_QMUL2;
        end
      end
      S_QMUL2: begin
        if (mm_done) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ST_OK;
          of_nxt    = fn_r;
          oi_nxt    = ifn_r;
          oc_nxt    = mm_res;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fact_we) fact_mem[fact_wa] <= fact_wd;
    if (inv_we)  inv_mem[inv_wa]   <= inv_wd;
    fact_q_r <= fact_mem[fact_ra];
    inv_q_r  <= inv_mem[inv_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
      limit_r   <= LIMIT_RESET;
      built_r   <= 1'b0;
      blim_r    <= '0;
      state_r   <= S_IDLE;
      req_r.go  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_MODULUS) modulus_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_LIMIT)   limit_r   <= cfg_wdata[IDX_W-1:0];
      built_r  <= built_nxt;
      blim_r   <= blim_nxt;
      state_r  <= state_nxt;
      req_r.go <= req_nxt.go;
      ov_r     <= ov_nxt;
    end
    req_r.a <= req_nxt.a;
    req_r.b <= req_nxt.b;
    req_r.m <= req_nxt.m;
    m_r     <= m_nxt;
    one_r   <= one_nxt;
    cur_r   <= cur_nxt;
    base_r  <= base_nxt;
    exp_r   <= exp_nxt;
    fn_r    <= fn_nxt;
    ifn_r   <= ifn_nxt;
    lim_r   <= lim_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
    r_r     <= r_nxt;
    ecnt_r  <= ecnt_nxt;
    ost_r   <= ost_nxt;
    of_r    <= of_nxt;
    oi_r    <= oi_nxt;
    op_r    <= op_nxt;
    oc_r    <= oc_nxt;
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = ov_r;
  assign out_status            = ost_r;
  assign out_factorial         = of_r;
  assign out_inverse_factorial = oi_r;
  assign out_permutations      = op_r;
  assign out_combinations      = oc_r;

endmodule

// ===== design/bmpt_checker.sv =====
// ----------------------------------------------------------------------------
// bmpt_checker: port-level checks for the factorial table core
// Watches status codes, error results and the end of long requests.
// ----------------------------------------------------------------------------
module bmpt_checker
  import bmpt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              busy,
  input logic              out_valid,
  input logic [1:0]        out_status,
  input logic [DATA_W-1:0] out_factorial,
  input logic [DATA_W-1:0] out_inverse_factorial,
  input logic [DATA_W-1:0] out_permutations,
  input logic [DATA_W-1:0] out_combinations
);

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE ||
                   out_status == ST_NOT_BUILT))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |->
      (out_factorial == '0 && out_inverse_factorial == '0 &&
       out_permutations == '0 && out_combinations == '0))
    else $error("error result carries data");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("long request ended without a result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("activity straight after reset");

endmodule

bind binomial_mod_prime_table_core bmpt_checker u_bmpt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_status            (out_status),
  .out_factorial         (out_factorial),
  .out_inverse_factorial (out_inverse_factorial),
  .out_permutations      (out_permutations),
  .out_combinations      (out_combinations)
);
